// ===== rtl/core/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the breath pressure conditioner: the item
// structs, register indexes, result codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

	// Field widths
	localparam int RAW_W   = 17;
	localparam int LEN_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int FILT_W  = 18;
	localparam int SUM_W   = 36;
	localparam int MAG_W   = SUM_W - 1;
	localparam int CNT_W   = 17;
	localparam int OUT_W   = 24;
	localparam int PROD_W  = FILT_W + GAIN_W;
	localparam int STEP_W  = $clog2(MAG_W + 1);

	// Configuration register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_SENSOR_OFFSET = 2'd0;
	localparam logic [IDX_W-1:0] REG_PRESSURE_GAIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_CALIB_COUNT   = 2'd2;

	// Register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET       = 16'd256;
	localparam logic [LEN_W-1:0]  CALIB_CNT_RESET  = 16'd20;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_RECAL  = 1'b1;

	// Result codes
	localparam logic [1:0] RES_CALIB = 2'd0;
	localparam logic [1:0] RES_DONE  = 2'd1;
	localparam logic [1:0] RES_MEAS  = 2'd2;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	typedef struct packed {
		logic             kind;
		logic [RAW_W-1:0] reading;
		logic [LEN_W-1:0] calib_length;
	} sample_t;

	typedef struct packed {
		logic             pressure_valid;
		logic [OUT_W-1:0] breath_pressure;
		logic             calib_done;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic       recal;
		logic       load_sample;
		logic       filter;
		logic       accum;
		logic       diff;
		logic       mul;
		logic       div_start;
		logic       set_baseline;
		logic       out_load;
		logic [1:0] res_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic calib_active;
		logic calib_last;
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Restoring unsigned divider, one quotient bit per cycle. Divides the
// calibration sum magnitude by the sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bpc_pkg::MAG_W-1:0]   dividend,
	input  wire logic [bpc_pkg::CNT_W-1:0]   divisor,
	output logic                             done,
	output logic [bpc_pkg::MAG_W-1:0]        quotient
);

	logic [bpc_pkg::STEP_W-1:0] step_q;
	logic [bpc_pkg::MAG_W-1:0]  dvd_q;
	logic [bpc_pkg::CNT_W-1:0]  dvr_q;
	logic [bpc_pkg::CNT_W-1:0]  rem_q;
	logic                       done_q;
	logic [bpc_pkg::CNT_W:0]    rem_sh;
	logic [bpc_pkg::CNT_W:0]    rem_sub;
	logic                       ge;

	// Shift in the next dividend bit and trial-subtract
	assign rem_sh  = {rem_q, dvd_q[bpc_pkg::MAG_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvr_q};
	assign ge      = rem_sh >= {1'b0, dvr_q};

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= bpc_pkg::STEP_W'(bpc_pkg::MAG_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == bpc_pkg::STEP_W'(1));
			if (step_q != '0) begin
				step_q <= step_q - bpc_pkg::STEP_W'(1);
			end
		end
	end

	// Quotient bits fill in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[bpc_pkg::MAG_W-2:0], ge};
			rem_q <= ge ? rem_sub[bpc_pkg::CNT_W-1:0] : rem_sh[bpc_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	a_done_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (step_q == '0))
		else $error("divider done while still stepping");

	a_start_loads_count: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (step_q == bpc_pkg::STEP_W'(bpc_pkg::MAG_W)) && !done_q)
		else $error("divider start did not load the step count");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/bpc_datapath.sv =====
// ----------------------------------------------------------------------------
// bpc_datapath
// Offset removal, 3-tap median, calibration accumulator and baseline divide,
// gain multiply with clamp and saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bpc_pkg::sample_t            sample,
	input  wire logic                        wr_en,
	input  wire logic [bpc_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [bpc_pkg::RAW_W-1:0]   wr_data,
	input  wire bpc_pkg::cmd_t               cmd,
	output bpc_pkg::status_t                 status,
	output bpc_pkg::result_t                 result
);

	// Configuration
	logic [bpc_pkg::RAW_W-1:0]          offset_q;
	logic [bpc_pkg::GAIN_W-1:0]         gain_q;

	// Sample and filter
	logic [bpc_pkg::RAW_W-1:0]          raw_q;
	logic signed [bpc_pkg::FILT_W-1:0]  filt_q;
	logic signed [bpc_pkg::FILT_W-1:0]  older_q;
	logic signed [bpc_pkg::FILT_W-1:0]  newer_q;
	logic                               primed_q;

	// Calibration
	logic signed [bpc_pkg::FILT_W-1:0]  countdown_q;
	logic signed [bpc_pkg::SUM_W-1:0]   sum_q;
	logic [bpc_pkg::CNT_W-1:0]          samples_q;
	logic signed [bpc_pkg::FILT_W-1:0]  baseline_q;
	logic                               neg_q;

	// Scaling
	logic [bpc_pkg::FILT_W-1:0]         mag_q;
	logic                               pos_q;
	logic [bpc_pkg::PROD_W-1:0]         prod_q;
	bpc_pkg::result_t                   result_q;

	logic signed [bpc_pkg::FILT_W-1:0]  v;
	logic signed [bpc_pkg::FILT_W-1:0]  tap_a;
	logic signed [bpc_pkg::FILT_W-1:0]  tap_b;
	logic signed [bpc_pkg::FILT_W-1:0]  lo;
	logic signed [bpc_pkg::FILT_W-1:0]  hi;
	logic signed [bpc_pkg::FILT_W-1:0]  med;
	logic signed [bpc_pkg::SUM_W-1:0]   sum_neg;
	logic [bpc_pkg::MAG_W-1:0]          sum_mag;
	logic signed [bpc_pkg::FILT_W:0]    diff;
	logic [bpc_pkg::PROD_W-1:0]         prod;
	logic [bpc_pkg::PROD_W-9:0]         scaled;
	logic [bpc_pkg::OUT_W-1:0]          sat;
	logic                               div_done;
	logic [bpc_pkg::MAG_W-1:0]          quotient;
	logic signed [bpc_pkg::FILT_W-1:0]  quo_s;
	bpc_pkg::result_t                   res_next;

	// Offset removal and median of three; an unprimed history takes the sample
	assign v     = $signed({1'b0, raw_q}) - $signed({1'b0, offset_q});
	assign tap_a = primed_q ? older_q : v;
	assign tap_b = primed_q ? newer_q : v;
	assign lo    = (tap_a < tap_b) ? tap_a : tap_b;
	assign hi    = (tap_a < tap_b) ? tap_b : tap_a;
	assign med   = (v < lo) ? lo : ((v > hi) ? hi : v);

	// Sum magnitude for the divider
	assign sum_neg = -sum_q;
	assign sum_mag = sum_q[bpc_pkg::SUM_W-1] ? sum_neg[bpc_pkg::MAG_W-1:0]
		: sum_q[bpc_pkg::MAG_W-1:0];

	// Difference above baseline
	assign diff = $signed({filt_q[bpc_pkg::FILT_W-1], filt_q})
		- $signed({baseline_q[bpc_pkg::FILT_W-1], baseline_q});

	assign prod   = mag_q * gain_q;
	assign scaled = prod_q[bpc_pkg::PROD_W-1:8];
	assign sat    = (|scaled[bpc_pkg::PROD_W-9:bpc_pkg::OUT_W]) ? bpc_pkg::OUT_MAX
		: scaled[bpc_pkg::OUT_W-1:0];

	assign quo_s = $signed(quotient[bpc_pkg::FILT_W-1:0]);

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (samples_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			gain_q   <= bpc_pkg::GAIN_RESET;
		end else if (wr_en) begin
			if (wr_index == bpc_pkg::REG_SENSOR_OFFSET) begin
				offset_q <= wr_data;
			end
			if (wr_index == bpc_pkg::REG_PRESSURE_GAIN) begin
				gain_q <= wr_data[bpc_pkg::GAIN_W-1:0];
			end
		end
	end

	// Median history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			newer_q  <= '0;
			primed_q <= 1'b0;
		end else if (cmd.filter) begin
			older_q  <= tap_b;
			newer_q  <= v;
			primed_q <= 1'b1;
		end
	end

	// Calibration state; a write of the count register restarts calibration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= $signed({2'b00, bpc_pkg::CALIB_CNT_RESET});
			sum_q       <= '0;
			samples_q   <= '0;
			baseline_q  <= '1;
		end else begin
			if (cmd.recal) begin
				countdown_q <= $signed({2'b00, sample.calib_length});
				sum_q       <= '0;
				samples_q   <= '0;
			end else if (cmd.accum) begin
				countdown_q <= countdown_q - $signed(bpc_pkg::FILT_W'(1));
				sum_q       <= sum_q + {{(bpc_pkg::SUM_W-bpc_pkg::FILT_W){filt_q[bpc_pkg::FILT_W-1]}},
					filt_q};
				samples_q   <= samples_q + bpc_pkg::CNT_W'(1);
			end
			if (cmd.set_baseline) begin
				baseline_q <= neg_q ? -quo_s : quo_s;
			end
			if (wr_en && (wr_index == bpc_pkg::REG_CALIB_COUNT)) begin
				countdown_q <= $signed({2'b00, wr_data[bpc_pkg::LEN_W-1:0]});
				sum_q       <= '0;
				samples_q   <= '0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			raw_q <= sample.reading;
		end
		if (cmd.filter) begin
			filt_q <= med;
		end
		if (cmd.div_start) begin
			neg_q <= sum_q[bpc_pkg::SUM_W-1];
		end
		if (cmd.diff) begin
			mag_q <= diff[bpc_pkg::FILT_W-1:0];
			pos_q <= !diff[bpc_pkg::FILT_W] && (|diff[bpc_pkg::FILT_W-1:0]);
		end
		if (cmd.mul) begin
			prod_q <= pos_q ? prod : '0;
		end
		if (cmd.out_load) begin
			result_q <= res_next;
		end
	end

	// Build the result item
	always_comb begin
		res_next = '0;
		case (cmd.res_sel)
			bpc_pkg::RES_DONE: begin
				res_next.calib_done = 1'b1;
			end
			bpc_pkg::RES_MEAS: begin
				res_next.pressure_valid  = 1'b1;
				res_next.breath_pressure = sat;
			end
			default: begin
				res_next = '0;
			end
		endcase
	end

	assign status.calib_active = !countdown_q[bpc_pkg::FILT_W-1];
	assign status.calib_last   = (countdown_q == '0);
	assign status.div_done     = div_done;
	assign result              = result_q;

	a_countdown_floor: assert property (@(posedge clk) disable iff (!arst_n)
		countdown_q[bpc_pkg::FILT_W-1] |-> (countdown_q == '1))
		else $error("calibration countdown went below minus one");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (quotient[bpc_pkg::MAG_W-1:bpc_pkg::RAW_W] == '0))
		else $error("baseline quotient exceeds the sample range");

	a_divide_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (samples_q != '0))
		else $error("baseline divide started with no samples");

endmodule

`default_nettype wire

// ===== rtl/core/bpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer for one item at a time: accept, filter, calibrate or scale,
// baseline divide, and hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	input  wire logic               sample_kind,
	output logic                    sample_stall,
	output logic                    result_valid,
	input  wire logic               result_stall,
	input  wire bpc_pkg::status_t   status,
	output bpc_pkg::cmd_t           cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FILT  = 3'd1;
	localparam logic [2:0] S_CALC  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DLOAD = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] res_q;
	logic [1:0] res_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !out_valid_q || !result_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res_sel = res_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sample_kind == bpc_pkg::KIND_RECAL) begin
						cmd.recal = 1'b1;
					end else begin
						cmd.load_sample = 1'b1;
						state_d = S_FILT;
					end
				end
			end
			S_FILT: begin
				cmd.filter = 1'b1;
				state_d = S_CALC;
			end
			S_CALC: begin
				if (status.calib_active) begin
					cmd.accum = 1'b1;
					if (status.calib_last) begin
						state_d = S_DLOAD;
					end else begin
						res_d   = bpc_pkg::RES_CALIB;
						state_d = S_OUT;
					end
				end else begin
					cmd.diff = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				res_d   = bpc_pkg::RES_MEAS;
				state_d = S_OUT;
			end
			S_DLOAD: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.set_baseline = 1'b1;
					res_d   = bpc_pkg::RES_DONE;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, result code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= bpc_pkg::RES_CALIB;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			out_valid_q <= cmd.out_load || (out_valid_q && result_stall);
		end
	end

	assign result_valid = out_valid_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_valid_rises_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the hand-off state");

	a_calib_end_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) && status.calib_active && status.calib_last |=>
		(state_q == S_DLOAD))
		else $error("last calibration sample did not start the divide");

endmodule

`default_nettype wire

// ===== rtl/core/breath_pressure_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// breath_pressure_conditioner_top
// Pressure sample conditioner: offset removal, 3-tap median, baseline
// calibration by averaging, and Q8.8 gain with clamp and saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  sample    in         sample_valid / sample_stall  bpc_pkg::sample_t
//  result    out        result_valid / result_stall  bpc_pkg::result_t
//  config    in         wr_en                        wr_index, wr_data
//
//  A measured sample passes the raw, filtered, difference and product
//  registers to the result register, a calibrating sample the raw and
//  filtered registers; the input reopens as the result register loads.
//  The sample that ends calibration first runs a restoring divide of the sum
//  by the sample count; a recalibrate item gives no result. A waiting result
//  stalls the input only once a second result is ready behind it.
//  Reset loads the calibration countdown with 20 and the baseline with -1.
//
`default_nettype none

module breath_pressure_conditioner_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_valid,
	output logic                             sample_stall,
	input  wire bpc_pkg::sample_t            sample,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output bpc_pkg::result_t                 result,
	input  wire logic                        wr_en,
	input  wire logic [bpc_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [bpc_pkg::RAW_W-1:0]   wr_data
);

	bpc_pkg::cmd_t    cmd;
	bpc_pkg::status_t status;

	bpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_kind  (sample.kind),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	bpc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== test/bpc_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_result_checker
// Watches the sample, result and register-write ports of the breath pressure
// conditioner, predicts every result from the accepted items and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module bpc_result_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	input  logic                                 sample_stall,
	input  bpc_pkg::sample_t                     sample,
	input  logic                                 result_valid,
	input  logic                                 result_stall,
	input  bpc_pkg::result_t                     result,
	input  logic                                 wr_en,
	input  logic [bpc_pkg::IDX_W-1:0]            wr_index,
	input  logic [bpc_pkg::RAW_W-1:0]            wr_data,
	output int                                   errors,
	output int                                   outstanding
);

	// Shadow registers
	logic [bpc_pkg::RAW_W-1:0]         offset_reg;
	logic [bpc_pkg::GAIN_W-1:0]        gain_reg;

	// Shadow conditioning state
	logic signed [bpc_pkg::FILT_W-1:0] hist_older;
	logic signed [bpc_pkg::FILT_W-1:0] hist_newer;
	bit                                hist_primed;
	logic signed [bpc_pkg::FILT_W-1:0] countdown;
	logic signed [bpc_pkg::SUM_W-1:0]  calib_acc;
	logic [bpc_pkg::CNT_W-1:0]         calib_n;
	logic signed [bpc_pkg::FILT_W-1:0] baseline_level;

	bpc_pkg::result_t                  expected_results[$];
	int                                mismatch_count;

	// Middle value of three signed samples
	function automatic logic signed [bpc_pkg::FILT_W-1:0] middle_of(
		input logic signed [bpc_pkg::FILT_W-1:0] a,
		input logic signed [bpc_pkg::FILT_W-1:0] b,
		input logic signed [bpc_pkg::FILT_W-1:0] c
	);
		if (a > b) begin
			return (b > c) ? b : ((a > c) ? c : a);
		end
		return (a > c) ? a : ((b > c) ? c : b);
	endfunction

	task automatic restart_calibration(input logic [bpc_pkg::LEN_W-1:0] len);
		calib_acc = '0;
		calib_n   = '0;
		countdown = $signed({2'b00, len});
	endtask

	task automatic apply_register_write(input logic [bpc_pkg::IDX_W-1:0] idx,
			input logic [bpc_pkg::RAW_W-1:0] data);
		case (idx)
			bpc_pkg::REG_SENSOR_OFFSET: offset_reg = data;
			bpc_pkg::REG_PRESSURE_GAIN: gain_reg = data[bpc_pkg::GAIN_W-1:0];
			bpc_pkg::REG_CALIB_COUNT:   restart_calibration(data[bpc_pkg::LEN_W-1:0]);
			default: ;
		endcase
	endtask

	// Predict the result of one accepted item, if it makes one
	task automatic condition_sample(input bpc_pkg::sample_t s);
		logic signed [bpc_pkg::FILT_W-1:0] v;
		logic signed [bpc_pkg::FILT_W-1:0] m;
		logic signed [63:0]                wide_acc;
		logic signed [63:0]                wide_n;
		logic signed [63:0]                wide_m;
		logic signed [63:0]                wide_base;
		logic signed [63:0]                diff;
		logic [63:0]                       scaled;
		bpc_pkg::result_t                  r;
		if (s.kind == bpc_pkg::KIND_RECAL) begin
			restart_calibration(s.calib_length);
			return;
		end
		v = $signed({1'b0, s.reading}) - $signed({1'b0, offset_reg});
		// first sample fills both history taps
		if (!hist_primed) begin
			hist_primed = 1'b1;
			hist_older  = v;
			hist_newer  = v;
		end
		m          = middle_of(hist_older, hist_newer, v);
		hist_older = hist_newer;
		hist_newer = v;
		r = '0;
		if (!countdown[bpc_pkg::FILT_W-1]) begin
			calib_acc = calib_acc + bpc_pkg::SUM_W'(m);
			calib_n   = calib_n + bpc_pkg::CNT_W'(1);
			if (countdown == '0) begin
				// signed divide truncates toward zero
				wide_acc       = 64'(calib_acc);
				wide_n         = (calib_n == '0) ? 64'sd1 : $signed({47'd0, calib_n});
				wide_acc       = wide_acc / wide_n;
				baseline_level = wide_acc[bpc_pkg::FILT_W-1:0];
				r.calib_done   = 1'b1;
			end
			countdown = countdown - $signed(bpc_pkg::FILT_W'(1));
		end else begin
			wide_m           = 64'(m);
			wide_base        = 64'(baseline_level);
			diff             = wide_m - wide_base;
			r.pressure_valid = 1'b1;
			// clamp below baseline at zero, saturate at the top
			if (diff > 64'sd0) begin
				scaled = ($unsigned(diff) * 64'(gain_reg)) >> 8;
				r.breath_pressure = (scaled > 64'(bpc_pkg::OUT_MAX)) ? bpc_pkg::OUT_MAX
					: scaled[bpc_pkg::OUT_W-1:0];
			end
		end
		expected_results.push_back(r);
	endtask

	task automatic check_result(input bpc_pkg::result_t got);
		bpc_pkg::result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with none expected: valid %0b pressure %0d done %0b",
				$time, got.pressure_valid, got.breath_pressure, got.calib_done);
			mismatch_count++;
			return;
		end
		want = expected_results.pop_front();
		if (got.pressure_valid !== want.pressure_valid) begin
			$display("%0t: pressure_valid expected %0b, got %0b",
				$time, want.pressure_valid, got.pressure_valid);
			mismatch_count++;
		end
		if (got.breath_pressure !== want.breath_pressure) begin
			$display("%0t: breath_pressure expected %0d, got %0d",
				$time, want.breath_pressure, got.breath_pressure);
			mismatch_count++;
		end
		if (got.calib_done !== want.calib_done) begin
			$display("%0t: calib_done expected %0b, got %0b",
				$time, want.calib_done, got.calib_done);
			mismatch_count++;
		end
	endtask

	// Retire results first, then register writes, then new items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_reg     = '0;
			gain_reg       = bpc_pkg::GAIN_RESET;
			hist_older     = '0;
			hist_newer     = '0;
			hist_primed    = 1'b0;
			baseline_level = '1;
			restart_calibration(bpc_pkg::CALIB_CNT_RESET);
			expected_results.delete();
			mismatch_count = 0;
		end else begin
			if (result_valid && !result_stall) check_result(result);
			if (wr_en) apply_register_write(wr_index, wr_data);
			if (sample_valid && !sample_stall) condition_sample(sample);
		end
		errors      <= mismatch_count;
		outstanding <= expected_results.size();
	end

endmodule

// ===== test/tb_breath_pressure_conditioner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breath_pressure_conditioner_top
// Drives sample items and register writes into the breath pressure
// conditioner: a directed pass over the extremes and special cases, then
// random phases with fresh register settings and random handshake gaps.
// The result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_breath_pressure_conditioner_top;

	localparam int ITEM_TARGET   = 950;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 600;
	localparam int RAW_MAX       = (1 << bpc_pkg::RAW_W) - 1;
	localparam int LEN_MAX       = (1 << bpc_pkg::LEN_W) - 1;
	localparam int GAIN_MAX      = (1 << bpc_pkg::GAIN_W) - 1;
	localparam int UNITY_GAIN    = 256;
	localparam int SAMPLE_W      = $bits(bpc_pkg::sample_t);
	localparam logic [bpc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	bpc_pkg::sample_t          sample       = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	bpc_pkg::result_t          result;
	logic                      wr_en        = 1'b0;
	logic [bpc_pkg::IDX_W-1:0] wr_index     = bpc_pkg::REG_SENSOR_OFFSET;
	logic [bpc_pkg::RAW_W-1:0] wr_data      = '0;

	int errors;
	int outstanding;
	int items_sent  = 0;
	int cycles      = 0;
	bit tx_burst    = 1'b0;
	bit rx_hold_req = 1'b0;

	breath_pressure_conditioner_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	bpc_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stall the result side: short bursts, rare long ones, open stretches,
	// and one long hold whenever the stimulus asks for it
	initial begin
		int len;
		int r;
		bit st;
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				st  = 1'b1;
				len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					st  = 1'b1;
					len = $urandom_range(1, 3);
				end else if (r < 35) begin
					st  = 1'b1;
					len = $urandom_range(15, 60);
				end else if (r < 40) begin
					st  = 1'b0;
					len = $urandom_range(80, 250);
				end else begin
					st  = 1'b0;
					len = $urandom_range(1, 8);
				end
			end
			result_stall <= st;
			repeat (len) begin
				@(posedge clk);
				if (rx_hold_req && !st) break;
			end
		end
	end

	function automatic int clamp_raw(input int v);
		return (v < 0) ? 0 : ((v > RAW_MAX) ? RAW_MAX : v);
	endfunction

	function automatic bpc_pkg::sample_t pressure(input int raw);
		bpc_pkg::sample_t s;
		s.kind         = bpc_pkg::KIND_SAMPLE;
		s.reading      = raw[bpc_pkg::RAW_W-1:0];
		s.calib_length = bpc_pkg::LEN_W'($urandom);
		return s;
	endfunction

	function automatic bpc_pkg::sample_t recalibrate(input int len);
		bpc_pkg::sample_t s;
		s.kind         = bpc_pkg::KIND_RECAL;
		s.reading      = bpc_pkg::RAW_W'($urandom);
		s.calib_length = len[bpc_pkg::LEN_W-1:0];
		return s;
	endfunction

	// Idle cycles after an item: mostly none or short, a few long
	function automatic int tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_burst || r < 45) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Mostly samples around the phase level, some anywhere, a few extremes,
	// and the odd recalibrate request
	function automatic bpc_pkg::sample_t random_item(input int level);
		int r;
		int sel;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			sel = $urandom_range(0, 19);
			if (sel < 16) return recalibrate($urandom_range(0, 12));
			if (sel < 19) return recalibrate($urandom_range(13, 300));
			return recalibrate($urandom_range(0, LEN_MAX));
		end
		if (r < 65) return pressure(clamp_raw(level + int'($urandom_range(0, 4000)) - 2000));
		if (r < 88) return pressure($urandom_range(0, RAW_MAX));
		return pressure((r % 2 == 0) ? 0 : RAW_MAX);
	endfunction

	// Offer one item, hold it until taken, then idle for gap cycles
	task automatic offer(input bpc_pkg::sample_t it, input int gap);
		sample_valid <= 1'b1;
		sample       <= it;
		do @(posedge clk); while (sample_stall);
		items_sent++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			sample       <= SAMPLE_W'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait for every predicted result, then let a trailing item finish
	task automatic wait_idle();
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bpc_pkg::IDX_W-1:0] idx, input int val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[bpc_pkg::RAW_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int off;
		int lvl;
		int n;
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a few calibrating samples, then a one-sample
		// calibration, clamp at zero, and a full-scale step
		offer(pressure(1000), tx_gap());
		offer(pressure(1000), tx_gap());
		offer(pressure(1000), tx_gap());
		offer(recalibrate(0), tx_gap());
		offer(pressure(1000), tx_gap());
		offer(pressure(0), tx_gap());
		offer(pressure(0), tx_gap());
		offer(pressure(RAW_MAX), tx_gap());
		offer(pressure(RAW_MAX), tx_gap());
		offer(recalibrate(LEN_MAX), tx_gap());
		offer(recalibrate(1), tx_gap());
		offer(pressure(500), tx_gap());
		offer(pressure(700), tx_gap() + 1);

		// Largest offset and gain: negative baseline, then saturation
		wait_idle();
		write_reg(bpc_pkg::REG_SENSOR_OFFSET, RAW_MAX);
		write_reg(bpc_pkg::REG_PRESSURE_GAIN, GAIN_MAX);
		write_reg(bpc_pkg::REG_CALIB_COUNT, 2);
		offer(pressure(0), tx_gap());
		offer(pressure(0), tx_gap());
		offer(pressure(0), tx_gap());
		offer(pressure(RAW_MAX), tx_gap());
		offer(pressure(RAW_MAX), tx_gap() + 1);

		// Zero gain, ignored write, longest then shortest startup count
		wait_idle();
		write_reg(REG_UNUSED, RAW_MAX);
		write_reg(bpc_pkg::REG_SENSOR_OFFSET, 0);
		write_reg(bpc_pkg::REG_PRESSURE_GAIN, 0);
		write_reg(bpc_pkg::REG_CALIB_COUNT, LEN_MAX);
		write_reg(bpc_pkg::REG_CALIB_COUNT, 0);
		offer(pressure(RAW_MAX), tx_gap());
		offer(pressure(0), tx_gap());
		offer(pressure(RAW_MAX), tx_gap());
		offer(pressure(RAW_MAX), tx_gap() + 1);

		// Random phases, each with fresh settings once the block is idle
		for (int p = 0; items_sent < ITEM_TARGET; p++) begin
			wait_idle();
			r   = $urandom_range(0, 9);
			off = (r < 3) ? 0 : ((r == 3) ? RAW_MAX :
				((r < 6) ? $urandom_range(0, 2000) : $urandom_range(0, RAW_MAX)));
			write_reg(bpc_pkg::REG_SENSOR_OFFSET, off);
			r = $urandom_range(0, 99);
			write_reg(bpc_pkg::REG_PRESSURE_GAIN, (r < 25) ? UNITY_GAIN :
				((r < 35) ? GAIN_MAX : ((r < 40) ? 0 : $urandom_range(0, GAIN_MAX))));
			r = $urandom_range(0, 9);
			if (r == 0) begin
				write_reg(bpc_pkg::REG_CALIB_COUNT, LEN_MAX);
			end else if (r < 6) begin
				write_reg(bpc_pkg::REG_CALIB_COUNT, $urandom_range(0, 12));
			end
			if (r == 1) write_reg(REG_UNUSED, $urandom_range(0, RAW_MAX));
			lvl = clamp_raw(off + int'($urandom_range(0, 30000)) - 5000);
			n   = $urandom_range(30, 90);
			tx_burst = (p % 4 == 3);
			// hold the result side while items keep coming
			if (p == 2 || p == 9) begin
				tx_burst    = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (r == 0 || $urandom_range(0, 3) == 0) begin
				offer(recalibrate($urandom_range(0, 12)), tx_gap());
			end
			for (int i = 0; i < n; i++) begin
				offer(random_item(lvl), (i == n - 1) ? tx_gap() + 1 : tx_gap());
			end
			tx_burst = 1'b0;
		end

		wait_idle();
		if (errors == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
